### rtl/kbd_pkg.sv
package kbd_pkg;

  // Matrix geometry
  localparam int ROWS = 4;
  localparam int COLS = 4;
  localparam int KEYS = 16;

  // Field widths
  localparam int ROW_W  = 2;
  localparam int LVL_W  = 4;
  localparam int KIND_W = 2;
  localparam int SC_W   = 4;
  localparam int PR_W   = 4;
  localparam int MAP_W  = 16;

  // Scan index into the key map
  localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

  // Job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Event kinds
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] EV_DONE    = 2'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_CLOSE
  } back_state_t;

  // front -> queue
  typedef struct packed {
    logic             push;
    logic [MAP_W-1:0] map;
  } q_wr_t;

  // queue -> back
  typedef struct packed {
    logic             valid;
    logic [MAP_W-1:0] map;
  } q_rd_t;

  // All valid key bits of row r
  function automatic logic [MAP_W-1:0] row_key_mask(input int r);
    logic [MAP_W-1:0] m;
    int code;
    m = '0;
    for (int c = 0; c < COLS; c++) begin
      code = r * COLS + c;
      if (code < KEYS && code < MAP_W) m[code] = 1'b1;
    end
    return m;
  endfunction

  // Pressed keys of one sampled row, placed at their scancodes
  function automatic logic [MAP_W-1:0] row_sample_map(input int r,
                                                       input logic [LVL_W-1:0] lv);
    logic [MAP_W-1:0] m;
    int code;
    m = '0;
    for (int c = 0; c < COLS && c < LVL_W; c++) begin
      code = r * COLS + c;
      if (code < KEYS && code < MAP_W && !lv[c]) m[code] = 1'b1;
    end
    return m;
  endfunction

endpackage

### rtl/kbd_if.sv
interface kbd_in_if import kbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic             second_pass;
  logic [LVL_W-1:0] column_levels;

  modport source(output valid, row_index, second_pass, column_levels, input ready);
  modport sink(input valid, row_index, second_pass, column_levels, output ready);
endinterface

interface kbd_out_if import kbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [SC_W-1:0]   scancode;
  logic [PR_W-1:0]   pressed_rows;
  logic              last_of_run;

  modport source(output valid, event_kind, scancode, pressed_rows, last_of_run,
                 input ready);
  modport sink(input valid, event_kind, scancode, pressed_rows, last_of_run,
               output ready);
endinterface

### rtl/kbd_front.sv
module kbd_front import kbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ROW_W-1:0] in_row_index,
  input  logic             in_second_pass,
  input  logic [LVL_W-1:0] in_column_levels,
  input  logic             q_full,
  output q_wr_t            q_wr
);

  logic [MAP_W-1:0] pass1_r, pass1_nxt;
  logic [MAP_W-1:0] pass2_r, pass2_nxt;
  logic [MAP_W-1:0] rowmap, rowmask, pass2_upd;
  logic             take, row_ok, done;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign row_ok   = int'(in_row_index) < ROWS;
  assign done     = row_ok && in_second_pass && (int'(in_row_index) == ROWS - 1);

  assign rowmap    = row_sample_map(int'(in_row_index), in_column_levels);
  assign rowmask   = row_key_mask(int'(in_row_index));
  assign pass2_upd = (pass2_r & ~rowmask) | rowmap;

  always_comb begin
    pass1_nxt  = pass1_r;
    pass2_nxt  = pass2_r;
    q_wr.push  = 1'b0;
    q_wr.map   = pass1_r & pass2_upd;
    if (take && row_ok) begin
      if (!in_second_pass) begin
        pass1_nxt = (pass1_r & ~rowmask) | rowmap;
      end else if (done) begin
        // scan closes: hand debounced map to the back end, start fresh
        q_wr.push = 1'b1;
        pass1_nxt = '0;
        pass2_nxt = '0;
      end else begin
        pass2_nxt = pass2_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass1_r <= '0;
      pass2_r <= '0;
    end else begin
      pass1_r <= pass1_nxt;
      pass2_r <= pass2_nxt;
    end
  end

endmodule

### rtl/kbd_queue.sv
module kbd_queue import kbd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  q_full,
  output q_rd_t q_rd,
  input  logic  q_pop
);

  logic [MAP_W-1:0] mem_r [Q_DEPTH];
  logic [Q_PW-1:0]  wp_r, rp_r;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_full     = (int'(cnt_r) == Q_DEPTH);
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.map   = mem_r[rp_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + Q_CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - Q_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= q_wr.map;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= (int'(wp_r) == Q_DEPTH - 1) ? '0 : wp_r + Q_PW'(1);
      if (do_pop)  rp_r <= (int'(rp_r) == Q_DEPTH - 1) ? '0 : rp_r + Q_PW'(1);
    end
  end

  // front must never push into a full queue, back never pops an empty one
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && q_full)) else $error("push while queue full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && !q_rd.valid)) else $error("pop while queue empty");

endmodule

### rtl/kbd_back.sv
module kbd_back import kbd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_rd_t             q_rd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_event_kind,
  output logic [SC_W-1:0]   out_scancode,
  output logic [PR_W-1:0]   out_pressed_rows,
  output logic              out_last_of_run
);

  back_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [MAP_W-1:0]  held_r, held_nxt;
  logic              ov_r, ov_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [SC_W-1:0]   sc_r, sc_nxt;
  logic [PR_W-1:0]   pr_r, pr_nxt;
  logic              last_r, last_nxt;
  logic              load_ok, key_now, key_was, idx_end;
  logic [PR_W-1:0]   rows_held;

  assign load_ok = !ov_r || out_ready;
  assign key_now = q_rd.map[idx_r];
  assign key_was = held_r[idx_r];
  assign idx_end = (int'(idx_r) == KEYS - 1);

  always_comb begin
    rows_held = '0;
    for (int r = 0; r < ROWS && r < PR_W; r++) begin
      rows_held[r] = |(held_r & row_key_mask(r));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (q_rd.valid) state_nxt = BK_SCAN;
      BK_SCAN:  if (load_ok && idx_end) state_nxt = BK_CLOSE;
      BK_CLOSE: if (load_ok) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt  = idx_r;
    held_nxt = held_r;
    ov_nxt   = ov_r && !out_ready;
    kind_nxt = kind_r;
    sc_nxt   = sc_r;
    pr_nxt   = pr_r;
    last_nxt = last_r;
    q_pop    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        idx_nxt = '0;
      end
      BK_SCAN: begin
        if (load_ok) begin
          if (key_now != key_was) begin
            ov_nxt   = 1'b1;
            kind_nxt = key_now ? EV_PRESS : EV_RELEASE;
            sc_nxt   = SC_W'(idx_r);
            pr_nxt   = '0;
            last_nxt = 1'b0;
            held_nxt[idx_r] = key_now;
          end
          if (!idx_end) idx_nxt = idx_r + IDX_W'(1);
        end
      end
      BK_CLOSE: begin
        if (load_ok) begin
          ov_nxt   = 1'b1;
          kind_nxt = EV_DONE;
          sc_nxt   = '0;
          pr_nxt   = rows_held;
          last_nxt = 1'b1;
          q_pop    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
      held_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      held_r  <= held_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    sc_r   <= sc_nxt;
    pr_r   <= pr_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_event_kind   = kind_r;
  assign out_scancode     = sc_r;
  assign out_pressed_rows = pr_r;
  assign out_last_of_run  = last_r;

  a_pop_only_close: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_CLOSE && q_rd.valid)) else $error("pop outside close");
  a_scan_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN) |-> q_rd.valid) else $error("scanning without job");
  a_close_after_last_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN && state_nxt == BK_CLOSE) |-> idx_end)
    else $error("close before last key");

endmodule

### rtl/keypad_matrix_scan_debounce.sv
// Channel   Dir  Payload                                              Handshake
// in_ch     in   row_index[1:0] second_pass column_levels[3:0]        valid/ready
// out_ch    out  event_kind[1:0] scancode[3:0] pressed_rows[3:0] last valid/ready
//
// A sample that does not close a scan is folded into the pass maps when taken.
// A closing sample (second pass, last row) is taken the same way; it queues a
// debounced map. The back end walks one key per cycle while the output is not
// stalled: an idle state, a scan state over all KEYS keys and one closing item.
// rst_n (sync, active low) clears pass maps, held keys, queue and output valid.
// Output stalls hold the key walk; in_ready drops only while the 2-deep job
// queue is full.
module keypad_matrix_scan_debounce import kbd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  kbd_in_if.sink    in_ch,
  kbd_out_if.source out_ch
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Front end: folds row samples into the two pass maps, emits debounced map.
  kbd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_row_index     (in_ch.row_index),
    .in_second_pass   (in_ch.second_pass),
    .in_column_levels (in_ch.column_levels),
    .q_full           (q_full),
    .q_wr             (q_wr)
  );

  // Short job queue decoupling sampling from event generation.
  kbd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // Back end: diffs each map against held keys, one key per cycle unless the
  // output stalls, registered output transaction, then the closing row summary.
  kbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rd             (q_rd),
    .q_pop            (q_pop),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_event_kind   (out_ch.event_kind),
    .out_scancode     (out_ch.scancode),
    .out_pressed_rows (out_ch.pressed_rows),
    .out_last_of_run  (out_ch.last_of_run)
  );

endmodule
